// ===== rtl/core/indexed_array_list_engine_core_macros.svh =====
// Assertion macros shared by the list engine RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef INDEXED_ARRAY_LIST_ENGINE_CORE_MACROS_SVH
`define INDEXED_ARRAY_LIST_ENGINE_CORE_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define IALE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Expression that must never be true outside reset.
`define IALE_NEVER(label, clk, rst_n, expr, msg) \
    `IALE_ASSERT(label, clk, rst_n, !(expr), msg)

`endif

// ===== rtl/core/iale_pkg.sv =====
// Shared types and codes of the indexed array list engine.
// Depends on nothing; imported by the core and its submodules.
package iale_pkg;

    localparam int unsigned KindW   = 3;
    localparam int unsigned IndexW  = 6;
    localparam int unsigned WordW   = 32;
    localparam int unsigned StatusW = 2;
    localparam int unsigned CountW  = 7;

    localparam logic [KindW-1:0] KIND_PUSH   = 3'd0;
    localparam logic [KindW-1:0] KIND_POP    = 3'd1;
    localparam logic [KindW-1:0] KIND_READ   = 3'd2;
    localparam logic [KindW-1:0] KIND_INSERT = 3'd3;
    localparam logic [KindW-1:0] KIND_DELETE = 3'd4;
    localparam logic [KindW-1:0] KIND_FIND   = 3'd5;
    localparam logic [KindW-1:0] KIND_REMOVE = 3'd6;

    localparam logic [StatusW-1:0] STATUS_OK    = 2'd0;
    localparam logic [StatusW-1:0] STATUS_RANGE = 2'd1;
    localparam logic [StatusW-1:0] STATUS_EMPTY = 2'd2;
    localparam logic [StatusW-1:0] STATUS_FULL  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [KindW-1:0]         kind;
        logic [IndexW-1:0]        index;
        logic signed [WordW-1:0]  value;
    } t_req;

    typedef struct packed {
        logic [StatusW-1:0]       status;
        logic signed [WordW-1:0]  read_value;
        logic                     found;
        logic [IndexW-1:0]        match_index;
        logic [CountW-1:0]        count;
        logic                     is_empty;
    } t_rsp;

endpackage

// ===== rtl/core/iale_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the element store of the list engine.
module iale_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/indexed_array_list_engine_core.sv =====
// Top level of the indexed array list engine: sequencer, step unit and store.
// Depends on iale_pkg, iale_ram and indexed_array_list_engine_core_macros.svh.
//
// Usage: requests arrive on the input channel (i_in_valid, o_in_ready,
// i_in_data) and each one yields exactly one result transaction on the output
// channel (o_out_valid, i_out_ready, o_out_data). One request is worked on at a
// time; o_in_ready is high only while the sequencer is idle and the result
// register is free or being taken in the same cycle, so a request is taken
// only once the previous one has left the sequencer.
// Path from acceptance to result valid: push and every error go from start
// straight to finish; pop, read, insert, delete, find and remove pass through
// the scan state between them. The walk is bound by the single read port of
// the store: one element is read per cycle and, in the next cycle, compared
// or moved by the shared compare and address step unit while the next read is
// already issued.
// Reset (synchronous, active low) empties the list and drops any pending
// result; the store itself is not cleared, since only entries below the count
// are ever read. When the receiver stalls, the result waits in its register
// and no new request is taken until that transaction completes.
module indexed_array_list_engine_core #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  iale_pkg::t_req i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output iale_pkg::t_rsp o_out_data
);
    import iale_pkg::*;

`include "indexed_array_list_engine_core_macros.svh"

    // Address width of the store, width of a count that can reach CAPACITY,
    // and widths that fit both a count or an address and the fixed port fields.
    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned LW = $clog2(CAPACITY + 1);
    localparam int unsigned CW = (LW > IndexW) ? LW : IndexW;
    localparam int unsigned NW = (LW > CountW) ? LW : CountW;
    localparam int unsigned FW = (AW > IndexW) ? AW : IndexW;

    t_state             r_state, n_state;
    t_req               r_req,   n_req;
    logic [LW-1:0]      r_len,   n_len;
    logic [AW-1:0]      r_rp,    n_rp;
    logic [LW-1:0]      r_left,  n_left;
    logic               r_down,  n_down;
    logic               r_pv,    n_pv;
    logic [AW-1:0]      r_pa,    n_pa;
    logic [LW-1:0]      r_w,     n_w;
    logic               r_hit,   n_hit;
    logic [AW-1:0]      r_fidx,  n_fidx;
    logic [WordW-1:0]   r_rv,    n_rv;
    logic [StatusW-1:0] r_status, n_status;
    logic               r_ovalid, n_ovalid;
    t_rsp               r_out,   n_out;

    logic               in_accept;
    logic               issue;
    logic               mem_we, mem_re;
    logic [AW-1:0]      mem_waddr, mem_raddr;
    logic [WordW-1:0]   mem_wdata, mem_rdata;

    logic [CW-1:0]      idx_c;
    logic [LW-1:0]      idx_l;
    logic               idx_bad, is_full, is_zero;
    logic [LW-1:0]      len_m1;
    logic               match;
    logic [NW-1:0]      cnt_ext;
    logic [FW-1:0]      fidx_ext;

    assign in_accept = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == ST_IDLE) && (!r_ovalid || i_out_ready);

    // Bounds checks on the stored request against the current count.
    assign idx_c   = CW'(r_req.index);
    assign idx_l   = idx_c[LW-1:0];
    assign idx_bad = idx_c >= CW'(r_len);
    assign is_full = r_len == LW'(CAPACITY);
    assign is_zero = r_len == '0;
    assign len_m1  = r_len - LW'(1);

    // Shared compare unit of the walk.
    assign match = mem_rdata == r_req.value;

    // A read is issued while elements remain and no match has ended a find.
    assign issue = (r_state == ST_SCAN) && (r_left != '0) && !r_hit;

    iale_ram #(
        .WIDTH (WordW),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = ST_START;
                end
            end
            ST_START: begin
                n_state = ST_FINISH;
                case (r_req.kind)
                    KIND_POP:    if (!is_zero) n_state = ST_SCAN;
                    KIND_READ:   if (!idx_bad) n_state = ST_SCAN;
                    KIND_INSERT: if (!idx_bad && !is_full) n_state = ST_SCAN;
                    KIND_DELETE: if (!idx_bad) n_state = ST_SCAN;
                    KIND_FIND:   n_state = ST_SCAN;
                    KIND_REMOVE: n_state = ST_SCAN;
                    default:     n_state = ST_FINISH;
                endcase
            end
            ST_SCAN: begin
                // The element in flight, if any, is handled in this cycle.
                if (!issue) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath, store control and result.
    always_comb begin
        n_req    = r_req;
        n_len    = r_len;
        n_rp     = r_rp;
        n_left   = r_left;
        n_down   = r_down;
        n_pv     = 1'b0;
        n_pa     = r_pa;
        n_w      = r_w;
        n_hit    = r_hit;
        n_fidx   = r_fidx;
        n_rv     = r_rv;
        n_status = r_status;
        n_ovalid = r_ovalid;
        n_out    = r_out;
        mem_we    = 1'b0;
        mem_waddr = r_pa;
        mem_wdata = mem_rdata;
        mem_re    = 1'b0;
        mem_raddr = r_rp;
        cnt_ext   = '0;
        fidx_ext  = '0;

        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_req = i_in_data;
                end
            end
            ST_START: begin
                n_status = STATUS_OK;
                n_hit    = 1'b0;
                n_fidx   = '0;
                n_rv     = '0;
                n_w      = '0;
                n_down   = 1'b0;
                n_rp     = '0;
                n_left   = '0;
                case (r_req.kind)
                    KIND_PUSH: begin
                        if (is_full) begin
                            n_status = STATUS_FULL;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = r_len[AW-1:0];
                            mem_wdata = r_req.value;
                        end
                    end
                    KIND_POP: begin
                        if (is_zero) begin
                            n_status = STATUS_EMPTY;
                        end else begin
                            n_rp   = len_m1[AW-1:0];
                            n_left = LW'(1);
                        end
                    end
                    KIND_READ: begin
                        if (idx_bad) begin
                            n_status = STATUS_RANGE;
                        end else begin
                            n_rp   = idx_l[AW-1:0];
                            n_left = LW'(1);
                        end
                    end
                    KIND_INSERT: begin
                        // Walk from the last element down to the index.
                        if (idx_bad) begin
                            n_status = STATUS_RANGE;
                        end else if (is_full) begin
                            n_status = STATUS_FULL;
                        end else begin
                            n_rp   = len_m1[AW-1:0];
                            n_left = r_len - idx_l;
                            n_down = 1'b1;
                        end
                    end
                    KIND_DELETE: begin
                        // Walk from the element after the index up to the end.
                        if (idx_bad) begin
                            n_status = STATUS_RANGE;
                        end else begin
                            n_rp   = idx_l[AW-1:0] + AW'(1);
                            n_left = len_m1 - idx_l;
                        end
                    end
                    KIND_FIND, KIND_REMOVE: begin
                        n_left = r_len;
                    end
                    default: begin
                        n_left = '0;
                    end
                endcase
            end
            ST_SCAN: begin
                if (issue) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_rp;
                    n_rp      = r_down ? (r_rp - AW'(1)) : (r_rp + AW'(1));
                    n_left    = r_left - LW'(1);
                    n_pv      = 1'b1;
                    n_pa      = r_rp;
                end
                if (r_pv) begin
                    case (r_req.kind)
                        KIND_POP, KIND_READ: begin
                            n_rv = mem_rdata;
                        end
                        KIND_INSERT: begin
                            mem_we    = 1'b1;
                            mem_waddr = r_pa + AW'(1);
                        end
                        KIND_DELETE: begin
                            mem_we    = 1'b1;
                            mem_waddr = r_pa - AW'(1);
                        end
                        KIND_FIND: begin
                            if (match && !r_hit) begin
                                n_hit  = 1'b1;
                                n_fidx = r_pa;
                            end
                        end
                        KIND_REMOVE: begin
                            // Keep non-matching words, packed toward the front.
                            if (!match) begin
                                mem_we    = 1'b1;
                                mem_waddr = r_w[AW-1:0];
                                n_w       = r_w + LW'(1);
                            end
                        end
                        default: begin
                            mem_we = 1'b0;
                        end
                    endcase
                end
            end
            ST_FINISH: begin
                if (r_status == STATUS_OK) begin
                    case (r_req.kind)
                        KIND_PUSH:   n_len = r_len + LW'(1);
                        KIND_POP:    n_len = len_m1;
                        KIND_INSERT: begin
                            mem_we    = 1'b1;
                            mem_waddr = idx_l[AW-1:0];
                            mem_wdata = r_req.value;
                            n_len     = r_len + LW'(1);
                        end
                        KIND_DELETE: n_len = len_m1;
                        KIND_REMOVE: n_len = r_w;
                        default:     n_len = r_len;
                    endcase
                end
                cnt_ext  = NW'(n_len);
                fidx_ext = FW'(r_fidx);
                n_out.status      = r_status;
                n_out.read_value  = ((r_status == STATUS_OK) &&
                                     ((r_req.kind == KIND_POP) ||
                                      (r_req.kind == KIND_READ))) ? r_rv : '0;
                n_out.found       = (r_req.kind == KIND_FIND) && r_hit;
                n_out.match_index = ((r_req.kind == KIND_FIND) && r_hit) ?
                                    fidx_ext[IndexW-1:0] : '0;
                n_out.count       = cnt_ext[CountW-1:0];
                n_out.is_empty    = n_len == '0;
                n_ovalid          = 1'b1;
            end
            default: begin
                n_pv = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_len    <= '0;
            r_ovalid <= 1'b0;
            r_pv     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_ovalid <= n_ovalid;
            r_pv     <= n_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_rp     <= n_rp;
        r_left   <= n_left;
        r_down   <= n_down;
        r_pa     <= n_pa;
        r_w      <= n_w;
        r_hit    <= n_hit;
        r_fidx   <= n_fidx;
        r_rv     <= n_rv;
        r_status <= n_status;
        r_out    <= n_out;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    // The count can never pass the capacity of the store.
    `IALE_NEVER(a_len_bound, i_clk, i_rst_n, r_len > LW'(CAPACITY),
        "list count exceeds capacity")
    // A walk never reads the word that is being written in the same cycle.
    `IALE_NEVER(a_no_rw_clash, i_clk, i_rst_n,
        mem_we && mem_re && (mem_waddr == mem_raddr),
        "store read and write hit the same entry")
    // A new result only appears out of the finish step.
    `IALE_ASSERT(a_result_source, i_clk, i_rst_n,
        $rose(o_out_valid) |-> $past(r_state == ST_FINISH),
        "result raised outside the finish step")
    // A walk never has more reads left than elements in the list.
    `IALE_NEVER(a_walk_bound, i_clk, i_rst_n,
        (r_state == ST_SCAN) && (r_left > r_len),
        "walk length exceeds list count")

endmodule
